FILE: src/scil_pkg.sv
`default_nettype none

package scil_pkg;

    localparam int ANGLE_W = 16;
    localparam int VALUE_W = 16;
    localparam int MAG_W   = 15;
    localparam int IDX_W   = 7;
    localparam int FRAC_W  = 7;
    localparam int DIFF_W  = 9;
    localparam int TABLE_ENTRIES = 128;

    localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'd32768;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;
    localparam logic [IDX_W-1:0]   LAST_IDX     = 7'd127;
    localparam logic [MAG_W-1:0]   TOP_WORD     = 15'd32766;

    localparam logic CMD_SINE   = 1'b0;
    localparam logic CMD_COSINE = 1'b1;

    localparam logic [MAG_W-1:0] QUARTER_WAVE [TABLE_ENTRIES] = '{
        15'd0,     15'd402,   15'd804,   15'd1206,  15'd1608,  15'd2009,  15'd2411,  15'd2811,
        15'd3212,  15'd3612,  15'd4011,  15'd4410,  15'd4808,  15'd5205,  15'd5602,  15'd5998,
        15'd6393,  15'd6787,  15'd7180,  15'd7571,  15'd7962,  15'd8351,  15'd8740,  15'd9127,
        15'd9512,  15'd9896,  15'd10279, 15'd10660, 15'd11039, 15'd11417, 15'd11793, 15'd12167,
        15'd12540, 15'd12910, 15'd13279, 15'd13646, 15'd14010, 15'd14373, 15'd14733, 15'd15091,
        15'd15447, 15'd15800, 15'd16151, 15'd16500, 15'd16846, 15'd17190, 15'd17531, 15'd17869,
        15'd18205, 15'd18538, 15'd18868, 15'd19195, 15'd19520, 15'd19841, 15'd20160, 15'd20475,
        15'd20788, 15'd21097, 15'd21403, 15'd21706, 15'd22006, 15'd22302, 15'd22595, 15'd22884,
        15'd23170, 15'd23453, 15'd23732, 15'd24008, 15'd24279, 15'd24548, 15'd24812, 15'd25073,
        15'd25330, 15'd25583, 15'd25833, 15'd26078, 15'd26320, 15'd26557, 15'd26791, 15'd27020,
        15'd27246, 15'd27467, 15'd27684, 15'd27897, 15'd28106, 15'd28311, 15'd28511, 15'd28707,
        15'd28899, 15'd29086, 15'd29269, 15'd29448, 15'd29622, 15'd29792, 15'd29957, 15'd30118,
        15'd30274, 15'd30425, 15'd30572, 15'd30715, 15'd30853, 15'd30986, 15'd31114, 15'd31238,
        15'd31357, 15'd31471, 15'd31581, 15'd31686, 15'd31786, 15'd31881, 15'd31972, 15'd32058,
        15'd32138, 15'd32214, 15'd32286, 15'd32352, 15'd32413, 15'd32470, 15'd32522, 15'd32568,
        15'd32610, 15'd32647, 15'd32679, 15'd32706, 15'd32729, 15'd32746, 15'd32758, 15'd32766
    };

endpackage

`default_nettype wire

FILE: src/sine_cosine_interpolated_lookup.sv
// Channel  Ports               Direction  Handshake
// -------  ------------------  ---------  ---------------------------------
// command  start, cmd, angle   in         taken when start is high, busy low
// result   done, value         out        one-cycle strobe on done
//
// One word is taken in every cycle; busy is always low.
// A word passes through two registers: the input register, then fold, table read,
// interpolation and sign restore into the result register.
// Reset clears the strobes only; no word is produced until one is taken.
// The receiver cannot stall, so every result appears for exactly one cycle.
`default_nettype none

module sine_cosine_interpolated_lookup
    import scil_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      cmd,
    input  wire logic [ANGLE_W-1:0]        angle,
    output logic                           done,
    output logic signed [VALUE_W-1:0]      value
);

    logic                      vld1_reg;
    logic                      cmd1_reg;
    logic [ANGLE_W-1:0]        angle1_reg;

    logic [MAG_W-1:0]          lo_next;
    logic [DIFF_W-1:0]         diff_next;
    logic                      neg_next;
    logic                      top_next;

    logic                      done_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    logic [ANGLE_W-1:0]        phase;
    logic [ANGLE_W-1:0]        half;
    logic [ANGLE_W-1:0]        folded;
    logic [IDX_W:0]            idx;
    logic [MAG_W-1:0]          hi;
    logic [MAG_W-1:0]          sub;
    logic [DIFF_W+FRAC_W-1:0]  prod;
    logic [MAG_W-1:0]          mag;

    // Fold the phase into the first quadrant and read both neighbouring entries.
    always_comb
    begin
        phase = (cmd1_reg == CMD_COSINE) ? angle1_reg + QUARTER_TURN : angle1_reg;
        neg_next = (phase > HALF_TURN);
        half = neg_next ? phase - HALF_TURN : phase;
        folded = (half > QUARTER_TURN) ? HALF_TURN - half : half;
        idx = folded[FRAC_W+IDX_W:FRAC_W];
        top_next = (idx >= {1'b0, LAST_IDX});
        lo_next = QUARTER_WAVE[idx[IDX_W-1:0]];
        hi = QUARTER_WAVE[idx[IDX_W-1:0] + IDX_W'(1)];
        sub = hi - lo_next;
        diff_next = sub[DIFF_W-1:0];
    end

    always_comb
    begin
        prod = DIFF_W'(diff_next) * FRAC_W'(folded[FRAC_W-1:0]);
        mag = top_next ? TOP_WORD : lo_next + MAG_W'(prod[DIFF_W+FRAC_W-1:FRAC_W]);
        value_next = neg_next ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start;
            done_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg   <= cmd;
        angle1_reg <= angle;
        value_reg  <= value_next;
    end

    assign busy  = 1'b0;
    assign done  = done_reg;
    assign value = value_reg;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("accepted word did not give a result two cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start ##2 1'b1 |-> !done)
        else $error("result strobe without an accepted word");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (value <= 16'sd32766) && (value >= -16'sd32766))
        else $error("result outside the table range");

    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        vld1_reg && top_next |=> value == 16'sd32766 || value == -16'sd32766)
        else $error("top of table did not give the last table word");
`endif

endmodule

`default_nettype wire
